@@ hdl/clint_pkg.sv @@
// Shared types and constants of the core-local interruptor.
`default_nettype none

package clint_pkg;

	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_TICK  = 2'd2,
		OP_CHECK = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		REG_NONE,
		REG_SOFT,
		REG_CMP,
		REG_TIME
	} region_t;

	localparam logic [63:0] CMP_OFF    = 64'h0000_0000_0000_4000;
	localparam logic [63:0] TIME_OFF   = 64'h0000_0000_0000_BFF8;
	localparam logic [63:0] BASE_RESET = 64'h0000_0000_0200_0000;
	localparam logic [3:0]  MAX_BYTES  = 4'd8;
	localparam int          PEND_W     = 4;

	typedef struct packed {
		op_t         op;
		logic [63:0] address;
		logic [3:0]  access_bytes;
		logic [63:0] write_data;
		logic [63:0] increment;
		logic [1:0]  hart;
	} in_word_t;

	typedef struct packed {
		logic [63:0]       read_data;
		logic [PEND_W-1:0] soft_pending;
		logic [PEND_W-1:0] timer_pending;
	} out_word_t;

endpackage

`default_nettype wire

@@ hdl/clint_in_stage.sv @@
// Input register stage: holds one accepted word until the datapath takes it.
`default_nettype none

module clint_in_stage (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire clint_pkg::in_word_t in_data,
	input  wire logic                take,
	output logic                     valid_s1,
	output clint_pkg::in_word_t      word_s1
);

	logic accept;

	assign in_ready = !valid_s1 || take;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1 <= in_data;
		end
	end

endmodule

`default_nettype wire

@@ hdl/clint_core.sv @@
// Register state of the interruptor and the single-pass logic that serves one word.
`default_nettype none

module clint_core #(
	parameter int HARTS = 4
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [63:0]         cfg_wdata,
	input  wire logic                fire,
	input  wire clint_pkg::in_word_t word,
	output clint_pkg::out_word_t     result
);

	localparam int SOFT_LEN = 4 * HARTS;
	localparam int CMP_LEN  = 8 * HARTS;
	localparam int REL_W    = $clog2(CMP_LEN);
	localparam int LEN_W    = REL_W + 1;
	localparam int SOFT_IW  = $clog2(SOFT_LEN);
	localparam int FLAG_N   = (HARTS < clint_pkg::PEND_W) ? HARTS : clint_pkg::PEND_W;

	logic [63:0] base_q;
	logic [63:0] time_q;
	logic [63:0] cmp_q   [HARTS];
	logic [31:0] soft_q  [HARTS];
	logic [clint_pkg::PEND_W-1:0] flags_q;

	logic [7:0]  soft_b  [SOFT_LEN];
	logic [7:0]  cmp_b   [CMP_LEN];
	logic [7:0]  soft_nb [SOFT_LEN];
	logic [7:0]  cmp_nb  [CMP_LEN];
	logic [7:0]  time_nb [8];
	logic [63:0] cmp_next  [HARTS];
	logic [31:0] soft_next [HARTS];
	logic [CMP_LEN-1:0] cmp_hit;
	logic [63:0] time_wr;
	logic [63:0] time_next;

	logic [63:0] off;
	logic [63:0] off_cmp;
	logic [63:0] off_time;
	clint_pkg::region_t region;
	logic [REL_W-1:0] rel;
	logic [LEN_W-1:0] len;
	logic [3:0]       nbytes;
	logic             is_acc;
	logic             is_wr;
	logic [LEN_W-1:0] lane_p [8];
	logic [7:0]       mask;
	logic [63:0]      rdata;

	logic [clint_pkg::PEND_W-1:0] ge;
	logic [clint_pkg::PEND_W-1:0] touched;
	logic [clint_pkg::PEND_W-1:0] spend;
	logic [clint_pkg::PEND_W-1:0] flags_next;

	// Byte views of the register files, lowest byte of each register first.
	for (genvar j = 0; j < SOFT_LEN; j++) begin : g_soft_b
		assign soft_b[j] = soft_q[j / 4][8 * (j % 4) +: 8];
	end
	for (genvar j = 0; j < CMP_LEN; j++) begin : g_cmp_b
		assign cmp_b[j] = cmp_q[j / 8][8 * (j % 8) +: 8];
	end

	// The region is chosen by the offset of the first byte alone.
	assign off      = word.address - base_q;
	assign off_cmp  = off - clint_pkg::CMP_OFF;
	assign off_time = off - clint_pkg::TIME_OFF;

	always_comb begin
		region = clint_pkg::REG_NONE;
		rel    = '0;
		len    = '0;
		if (off < 64'(SOFT_LEN)) begin
			region = clint_pkg::REG_SOFT;
			rel    = off[REL_W-1:0];
			len    = LEN_W'(SOFT_LEN);
		end else if (off >= clint_pkg::CMP_OFF && off_cmp < 64'(CMP_LEN)) begin
			region = clint_pkg::REG_CMP;
			rel    = off_cmp[REL_W-1:0];
			len    = LEN_W'(CMP_LEN);
		end else if (off >= clint_pkg::TIME_OFF && off_time < 64'd8) begin
			region = clint_pkg::REG_TIME;
			rel    = off_time[REL_W-1:0];
			len    = LEN_W'(8);
		end
	end

	assign is_wr  = (word.op == clint_pkg::OP_WRITE);
	assign is_acc = (word.op == clint_pkg::OP_READ) || is_wr;
	assign nbytes = (word.access_bytes > clint_pkg::MAX_BYTES) ? clint_pkg::MAX_BYTES
		: word.access_bytes;

	// A lane moves a byte when it lies within the length and within the region.
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			lane_p[i] = {1'b0, rel} + LEN_W'(i);
			mask[i]   = is_acc && (4'(i) < nbytes) && (lane_p[i] < len);
		end
	end

	always_comb begin
		rdata = '0;
		for (int i = 0; i < 8; i++) begin
			if (mask[i] && word.op == clint_pkg::OP_READ) begin
				case (region)
					clint_pkg::REG_SOFT: rdata[8*i +: 8] = soft_b[lane_p[i][SOFT_IW-1:0]];
					clint_pkg::REG_CMP:  rdata[8*i +: 8] = cmp_b[lane_p[i][REL_W-1:0]];
					clint_pkg::REG_TIME: rdata[8*i +: 8] = time_q[{lane_p[i][2:0], 3'b000} +: 8];
					default:             rdata[8*i +: 8] = 8'h00;
				endcase
			end
		end
	end

	// Each stored byte finds the lane that would land on it, if any.
	for (genvar j = 0; j < SOFT_LEN; j++) begin : g_soft_w
		logic [LEN_W-1:0] d;
		logic             hit;
		assign d   = LEN_W'(j) - {1'b0, rel};
		assign hit = is_wr && region == clint_pkg::REG_SOFT && d[LEN_W-1:3] == '0
			&& mask[d[2:0]];
		assign soft_nb[j] = hit ? word.write_data[{d[2:0], 3'b000} +: 8] : soft_b[j];
	end
	for (genvar j = 0; j < CMP_LEN; j++) begin : g_cmp_w
		logic [LEN_W-1:0] d;
		assign d = LEN_W'(j) - {1'b0, rel};
		assign cmp_hit[j] = is_wr && region == clint_pkg::REG_CMP && d[LEN_W-1:3] == '0
			&& mask[d[2:0]];
		assign cmp_nb[j] = cmp_hit[j] ? word.write_data[{d[2:0], 3'b000} +: 8] : cmp_b[j];
	end
	for (genvar j = 0; j < 8; j++) begin : g_time_w
		logic [LEN_W-1:0] d;
		logic             hit;
		assign d   = LEN_W'(j) - {1'b0, rel};
		assign hit = is_wr && region == clint_pkg::REG_TIME && d[LEN_W-1:3] == '0
			&& mask[d[2:0]];
		assign time_nb[j]         = hit ? word.write_data[{d[2:0], 3'b000} +: 8]
			: time_q[8*j +: 8];
		assign time_wr[8*j +: 8] = time_nb[j];
	end

	for (genvar h = 0; h < HARTS; h++) begin : g_next
		assign soft_next[h] = {soft_nb[4*h+3], soft_nb[4*h+2], soft_nb[4*h+1], soft_nb[4*h]};
		assign cmp_next[h]  = {cmp_nb[8*h+7], cmp_nb[8*h+6], cmp_nb[8*h+5], cmp_nb[8*h+4],
			cmp_nb[8*h+3], cmp_nb[8*h+2], cmp_nb[8*h+1], cmp_nb[8*h]};
	end

	assign time_next = (word.op == clint_pkg::OP_TICK) ? time_q + word.increment : time_wr;

	// Only the first four harts own a pending bit.
	for (genvar h = 0; h < clint_pkg::PEND_W; h++) begin : g_pend
		if (h < FLAG_N) begin : g_on
			assign ge[h]      = (time_q >= cmp_next[h]);
			assign touched[h] = |cmp_hit[8*h +: 8];
			assign spend[h]   = soft_next[h][0];
		end else begin : g_off
			assign ge[h]      = 1'b0;
			assign touched[h] = 1'b0;
			assign spend[h]   = 1'b0;
		end
	end

	always_comb begin
		flags_next = flags_q;
		case (word.op)
			clint_pkg::OP_WRITE: begin
				for (int h = 0; h < clint_pkg::PEND_W; h++) begin
					if (touched[h]) begin
						flags_next[h] = ge[h];
					end
				end
			end
			clint_pkg::OP_CHECK: begin
				if (int'(word.hart) < FLAG_N && ge[word.hart]) begin
					flags_next[word.hart] = 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign result.read_data     = rdata;
	assign result.soft_pending  = spend;
	assign result.timer_pending = flags_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= clint_pkg::BASE_RESET;
		end else if (cfg_we) begin
			base_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q  <= '0;
			flags_q <= '0;
			for (int h = 0; h < HARTS; h++) begin
				cmp_q[h]  <= '0;
				soft_q[h] <= '0;
			end
		end else if (fire) begin
			time_q  <= time_next;
			flags_q <= flags_next;
			for (int h = 0; h < HARTS; h++) begin
				cmp_q[h]  <= cmp_next[h];
				soft_q[h] <= soft_next[h];
			end
		end
	end

endmodule

`default_nettype wire

@@ hdl/clint_out_stage.sv @@
// Result register: holds one result word until the consumer takes it.
`default_nettype none

module clint_out_stage (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 load,
	input  wire clint_pkg::out_word_t res,
	output logic                      free,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output clint_pkg::out_word_t      out_data
);

	logic                 valid_s2;
	clint_pkg::out_word_t word_s2;

	assign free      = !valid_s2 || out_ready;
	assign out_valid = valid_s2;
	assign out_data  = word_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			word_s2 <= res;
		end
	end

endmodule

`default_nettype wire

@@ hdl/core_local_interruptor.sv @@
// Top level of the core-local interruptor: input register, register state and result register.
// The block accepts one word per clock cycle while no stalled result holds it back. For each
// accepted word, the word is held in the input register, served in one pass through the
// register file logic into the result register, and drains at the consumer's pace. The
// window base is set through cfg_we and cfg_wdata and resets to 0x0200_0000; software
// words sit at offset 0x0, compares at 0x4000 and the time counter at 0xBFF8.
`default_nettype none

module core_local_interruptor #(
	parameter int HARTS = 4
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [63:0]         cfg_wdata,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire clint_pkg::in_word_t in_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output clint_pkg::out_word_t     out_data
);

	logic                 valid_s1;
	clint_pkg::in_word_t  word_s1;
	logic                 free;
	logic                 take;
	clint_pkg::out_word_t res;

	assign take = valid_s1 && free;

	clint_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.take     (take),
		.valid_s1 (valid_s1),
		.word_s1  (word_s1)
	);

	clint_core #(
		.HARTS (HARTS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.fire      (take),
		.word      (word_s1),
		.result    (res)
	);

	clint_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (take),
		.res       (res),
		.free      (free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

@@ hdl/clint_checker.sv @@
// Port-level checks on the interruptor, bound to the top level.
`default_nettype none

module clint_checker (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 in_valid,
	input wire logic                 in_ready,
	input wire logic                 out_valid,
	input wire logic                 out_ready,
	input wire clint_pkg::out_word_t out_data
);

	// A stalled result word must hold.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result word changed while stalled");

	// The input side only stalls behind a stalled result.
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without a stalled result");

	// A fresh result follows a word that was accepted and then taken from the input register.
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result appeared without an accepted word");

	// A word taken behind a stalled result fills the input register.
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready && in_valid && in_ready |=> !in_ready || out_ready)
		else $error("input register did not fill behind a stalled result");

endmodule

bind core_local_interruptor clint_checker u_chk (.*);

`default_nettype wire

@@ tb/sv/core_local_interruptor_checker.sv @@
// Checker for the core-local interruptor: predicts every result word and compares it.
module core_local_interruptor_checker #(
	parameter int HARTS = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [63:0]          cfg_wdata,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  clint_pkg::in_word_t  in_data,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  clint_pkg::out_word_t out_data,
	output int                   mismatches,
	output int                   outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [63:0] SOFT_SPAN = 64'(4 * HARTS);
	localparam logic [63:0] CMP_SPAN  = 64'(8 * HARTS);
	localparam logic [63:0] TIME_SPAN = 64'd8;

	logic [63:0] base_q;
	logic [63:0] time_q;
	logic [63:0] cmp_q [HARTS];
	logic [31:0] soft_q [HARTS];
	logic [3:0]  flags_q;

	clint_pkg::out_word_t predicted_words [$];

	// Applies one input word to the shadow state and returns the result word it causes.
	function automatic clint_pkg::out_word_t serve_word(clint_pkg::in_word_t w);
		logic [63:0] off;
		logic [63:0] rel;
		logic [63:0] span;
		logic [63:0] p;
		logic [63:0] rd;
		logic [HARTS-1:0] touched;
		clint_pkg::region_t reg_sel;
		int n;
		int idx;
		clint_pkg::out_word_t r;
		rd = '0;
		touched = '0;
		rel = '0;
		span = '0;
		reg_sel = clint_pkg::REG_NONE;
		n = (w.access_bytes > clint_pkg::MAX_BYTES) ? int'(clint_pkg::MAX_BYTES)
			: int'(w.access_bytes);
		case (w.op)
			clint_pkg::OP_READ, clint_pkg::OP_WRITE: begin
				off = w.address - base_q;
				if (off < SOFT_SPAN) begin
					reg_sel = clint_pkg::REG_SOFT;
					rel = off;
					span = SOFT_SPAN;
				end else if (off >= clint_pkg::CMP_OFF
					&& off - clint_pkg::CMP_OFF < CMP_SPAN) begin
					reg_sel = clint_pkg::REG_CMP;
					rel = off - clint_pkg::CMP_OFF;
					span = CMP_SPAN;
				end else if (off >= clint_pkg::TIME_OFF
					&& off - clint_pkg::TIME_OFF < TIME_SPAN) begin
					reg_sel = clint_pkg::REG_TIME;
					rel = off - clint_pkg::TIME_OFF;
					span = TIME_SPAN;
				end
				// The region is fixed by the first byte; later bytes past its end are dropped.
				for (int i = 0; i < n; i++) begin
					p = rel + 64'(i);
					if (reg_sel != clint_pkg::REG_NONE && p < span) begin
						case (reg_sel)
							clint_pkg::REG_SOFT: begin
								idx = int'((p >> 2) % HARTS);
								if (w.op == clint_pkg::OP_READ)
									rd[8*i +: 8] = soft_q[idx][8*p[1:0] +: 8];
								else
									soft_q[idx][8*p[1:0] +: 8] = w.write_data[8*i +: 8];
							end
							clint_pkg::REG_CMP: begin
								idx = int'((p >> 3) % HARTS);
								if (w.op == clint_pkg::OP_READ) begin
									rd[8*i +: 8] = cmp_q[idx][8*p[2:0] +: 8];
								end else begin
									cmp_q[idx][8*p[2:0] +: 8] = w.write_data[8*i +: 8];
									touched[idx] = 1'b1;
								end
							end
							default: begin
								if (w.op == clint_pkg::OP_READ)
									rd[8*i +: 8] = time_q[8*p[2:0] +: 8];
								else
									time_q[8*p[2:0] +: 8] = w.write_data[8*i +: 8];
							end
						endcase
					end
				end
				for (int h = 0; h < HARTS && h < 4; h++)
					if (touched[h])
						flags_q[h] = (time_q >= cmp_q[h]);
			end
			clint_pkg::OP_TICK: begin
				time_q = time_q + w.increment;
			end
			default: begin
				if (int'(w.hart) < HARTS && time_q >= cmp_q[int'(w.hart) % HARTS])
					flags_q[w.hart] = 1'b1;
			end
		endcase
		r.read_data = rd;
		r.soft_pending = '0;
		for (int h = 0; h < HARTS && h < 4; h++)
			r.soft_pending[h] = soft_q[h][0];
		r.timer_pending = flags_q;
		return r;
	endfunction

	task automatic note_mismatch(string what, logic [63:0] want, logic [63:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t ns: %s mismatch, expected %h, got %h", $realtime, what, want, got);
	endtask

	always @(posedge clk or negedge arst_n) begin
		clint_pkg::out_word_t want;
		if (!arst_n) begin
			base_q = clint_pkg::BASE_RESET;
			time_q = '0;
			flags_q = '0;
			for (int h = 0; h < HARTS; h++) begin
				cmp_q[h] = '0;
				soft_q[h] = '0;
			end
			predicted_words.delete();
		end else begin
			if (cfg_we)
				base_q = cfg_wdata;
			if (in_valid && in_ready)
				predicted_words.push_back(serve_word(in_data));
			if (out_valid && out_ready) begin
				if (predicted_words.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t ns: result word %h with nothing expected", $realtime,
							out_data);
				end else begin
					want = predicted_words.pop_front();
					if (out_data.read_data !== want.read_data)
						note_mismatch("read_data", want.read_data, out_data.read_data);
					if (out_data.soft_pending !== want.soft_pending)
						note_mismatch("soft_pending", 64'(want.soft_pending),
							64'(out_data.soft_pending));
					if (out_data.timer_pending !== want.timer_pending)
						note_mismatch("timer_pending", 64'(want.timer_pending),
							64'(out_data.timer_pending));
				end
			end
		end
		outstanding = predicted_words.size();
	end

endmodule

@@ tb/sv/core_local_interruptor_test.sv @@
// Top of the core-local interruptor testbench: clock, reset, stimulus and verdict.
module core_local_interruptor_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HARTS           = 4;
	localparam int WORDS_PER_PHASE = 500;
	localparam int HOLD_CYCLES     = 400;
	localparam int WATCHDOG_LIMIT  = 5000;
	localparam int DRAIN_CYCLES    = 8;
	localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [63:0]          cfg_wdata = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	clint_pkg::in_word_t  in_data = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	clint_pkg::out_word_t out_data;

	int          mismatches;
	int          outstanding;
	int          words_in = 0;
	int          words_out = 0;
	bit          calm = 1'b0;
	int          holds_asked = 0;
	logic [63:0] window_base = clint_pkg::BASE_RESET;

	always #2 clk = ~clk;

	core_local_interruptor #(
		.HARTS(HARTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	core_local_interruptor_checker #(
		.HARTS(HARTS)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	function automatic clint_pkg::in_word_t make_word(clint_pkg::op_t op, logic [63:0] addr,
		logic [3:0] n, logic [63:0] data, logic [63:0] incr, logic [1:0] h);
		clint_pkg::in_word_t w;
		w.op = op;
		w.address = addr;
		w.access_bytes = n;
		w.write_data = data;
		w.increment = incr;
		w.hart = h;
		return w;
	endfunction

	// Most accesses land in or just beside one of the three regions of the window.
	function automatic clint_pkg::in_word_t random_word(logic [63:0] base);
		clint_pkg::in_word_t w;
		logic [63:0] off;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 30)
			w.op = clint_pkg::OP_READ;
		else if (pick < 65)
			w.op = clint_pkg::OP_WRITE;
		else if (pick < 80)
			w.op = clint_pkg::OP_TICK;
		else
			w.op = clint_pkg::OP_CHECK;
		case ($urandom_range(0, 9))
			0, 1, 2: off = 64'($urandom_range(0, 19));
			3, 4, 5: off = clint_pkg::CMP_OFF - 64'd4 + 64'($urandom_range(0, 39));
			6, 7: off = clint_pkg::TIME_OFF - 64'd4 + 64'($urandom_range(0, 15));
			8: off = {$urandom, $urandom};
			default: off = 64'($urandom_range(0, 16'hFFFF));
		endcase
		w.address = base + off;
		if ($urandom_range(0, 3) == 0)
			w.access_bytes = 4'($urandom_range(0, 15));
		else
			w.access_bytes = 4'(1 << $urandom_range(0, 3));
		case ($urandom_range(0, 3))
			0: w.write_data = {$urandom, $urandom};
			1: w.write_data = 64'($urandom_range(0, 511));
			2: w.write_data = ALL_ONES;
			default: w.write_data = {32'h0, $urandom};
		endcase
		if ($urandom_range(0, 15) == 0)
			w.increment = {$urandom, $urandom};
		else
			w.increment = 64'($urandom_range(0, 64));
		w.hart = 2'($urandom_range(0, 3));
		return w;
	endfunction

	// Entered and left just after a falling edge; in_valid gets one assignment per edge.
	task automatic offer_word(input clint_pkg::in_word_t w);
		while (!calm && $urandom_range(0, 99) < 25) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic wait_for_drain();
		while (outstanding != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic set_base(input logic [63:0] value);
		cfg_wdata <= value;
		cfg_we <= 1'b1;
		window_base = value;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Receiver: random back-pressure, a calm stretch, and one long hold-off on request.
	initial begin
		int hold_left;
		int holds_done;
		hold_left = 0;
		holds_done = 0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (holds_done != holds_asked) begin
				holds_done++;
				hold_left = HOLD_CYCLES - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= calm || ($urandom_range(0, 99) >= 25);
			end
		end
	end

	// Watchdog: ends the run when no word moves on either channel for too long.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (in_valid && in_ready)
				words_in++;
			if (out_valid && out_ready)
				words_out++;
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("core_local_interruptor_test: no word moved for %0d cycles", WATCHDOG_LIMIT);
		$display("core_local_interruptor_test: done, errors");
		$finish;
	end

	initial begin
		logic [63:0] b;
		b = clint_pkg::BASE_RESET;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed words under the reset base.
		offer_word(make_word(clint_pkg::OP_READ, b + clint_pkg::TIME_OFF, 4'd8, '0, '0, 2'd0));
		offer_word(make_word(clint_pkg::OP_WRITE, b, 4'd4, 64'h1, '0, 2'd0));
		// Last soft word written with eight bytes: the upper half falls past the region.
		offer_word(make_word(clint_pkg::OP_WRITE, b + 64'd12, 4'd8, ALL_ONES, '0, 2'd0));
		offer_word(make_word(clint_pkg::OP_READ, b + 64'd8, 4'd15, '0, '0, 2'd0));
		offer_word(make_word(clint_pkg::OP_WRITE, b + clint_pkg::CMP_OFF + 64'd8, 4'd8,
			64'h10, '0, 2'd1));
		offer_word(make_word(clint_pkg::OP_CHECK, '0, 4'd0, '0, '0, 2'd1));
		offer_word(make_word(clint_pkg::OP_TICK, '0, 4'd0, '0, 64'h20, 2'd0));
		offer_word(make_word(clint_pkg::OP_CHECK, '0, 4'd0, '0, '0, 2'd1));
		// A compare write that runs from one hart's register into the next.
		offer_word(make_word(clint_pkg::OP_WRITE, b + clint_pkg::CMP_OFF + 64'd6, 4'd4,
			64'hFFFF_FFFF, '0, 2'd0));
		offer_word(make_word(clint_pkg::OP_READ, b + clint_pkg::CMP_OFF + 64'd4, 4'd8, '0,
			'0, 2'd0));
		offer_word(make_word(clint_pkg::OP_WRITE, b + clint_pkg::CMP_OFF + 64'd28, 4'd8,
			ALL_ONES, '0, 2'd3));
		offer_word(make_word(clint_pkg::OP_READ, b + clint_pkg::TIME_OFF + 64'd4, 4'd8, '0,
			'0, 2'd0));
		offer_word(make_word(clint_pkg::OP_WRITE, b + clint_pkg::TIME_OFF, 4'd8,
			64'hFFFF_FFFF_FFFF_FFF0, '0, 2'd0));
		offer_word(make_word(clint_pkg::OP_TICK, '0, 4'd0, '0, ALL_ONES, 2'd0));
		offer_word(make_word(clint_pkg::OP_CHECK, '0, 4'd0, '0, '0, 2'd0));
		offer_word(make_word(clint_pkg::OP_CHECK, '0, 4'd0, '0, '0, 2'd2));
		offer_word(make_word(clint_pkg::OP_CHECK, '0, 4'd0, '0, '0, 2'd3));
		offer_word(make_word(clint_pkg::OP_WRITE, b, 4'd0, ALL_ONES, '0, 2'd0));
		offer_word(make_word(clint_pkg::OP_READ, b + 64'h8000, 4'd8, '0, '0, 2'd0));
		offer_word(make_word(clint_pkg::OP_READ, '0, 4'd8, '0, '0, 2'd0));
		offer_word(make_word(clint_pkg::OP_WRITE, ALL_ONES, 4'd8, ALL_ONES, '0, 2'd0));
		offer_word(make_word(clint_pkg::OP_READ, b + 64'd20, 4'd4, '0, '0, 2'd0));
		offer_word(make_word(clint_pkg::OP_READ, b, 4'd8, '0, '0, 2'd0));

		// Random words over four window bases, the extremes among them.
		for (int ph = 0; ph < 4; ph++) begin
			if (ph > 0) begin
				in_valid <= 1'b0;
				@(negedge clk);
				wait_for_drain();
				case (ph)
					1: set_base('0);
					2: set_base(ALL_ONES);
					default: set_base({$urandom, $urandom});
				endcase
			end
			for (int k = 0; k < WORDS_PER_PHASE; k++) begin
				calm <= (ph == 1 && k >= 100 && k < 300);
				if (ph == 0 && k == 150)
					holds_asked <= holds_asked + 1;
				offer_word(random_word(window_base));
			end
		end
		in_valid <= 1'b0;
		@(negedge clk);
		wait_for_drain();

		$display("core_local_interruptor_test: %0d words sent, %0d results compared,",
			words_in, words_out);
		$display("core_local_interruptor_test: %0d mismatches over reset, zero, all-ones %s",
			mismatches, "and random window bases");
		if (mismatches == 0 && outstanding == 0)
			$display("core_local_interruptor_test: done, clean");
		else
			$display("core_local_interruptor_test: done, errors");
		$finish;
	end

endmodule
